// File: design/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, constants and the arctangent table of the Euler angle block.
// ----------------------------------------------------------------------------
package rme_pkg;

  // datapath width of the CORDIC x and y words (16 guard bits included)
  localparam int CW = 36;
  // guard bits added below the Q1.14 inputs
  localparam int GUARD_BITS = 16;
  // deepest supported stage count (size of the arctangent table)
  localparam int MAX_STAGES = 24;
  // inverse CORDIC gain, 0.60725 scaled by 2^16
  localparam logic [15:0] INV_GAIN = 16'd39797;

  // one matrix beat
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
  } rme_in_t;

  // one angle beat
  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               singular_flag;
  } rme_out_t;

  // atan(2^-i) in 32-bit turn units (2^32 = 2 pi)
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// File: design/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module rme_cordic
  import rme_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic        [31:0]   z_in,
  output logic signed [CW-1:0] x_out,
  output logic        [31:0]   z_out
);

  logic signed [CW-1:0] x_r [STAGES];
  logic signed [CW-1:0] y_r [STAGES-1];
  logic        [31:0]   z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [4:0] IDX = 5'(i);
    logic signed [CW-1:0] x_src;
    logic signed [CW-1:0] y_src;
    logic        [31:0]   z_src;

    if (i == 0) begin : g_first
      assign x_src = x_in;
      assign y_src = y_in;
      assign z_src = z_in;
    end else begin : g_next
      assign x_src = x_r[i-1];
      assign y_src = y_r[i-1];
      assign z_src = z_r[i-1];
    end

    // rotate towards the x axis, direction from the sign of y
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_src[CW-1]) begin
          x_r[i] <= x_src - (y_src >>> i);
          z_r[i] <= z_src - atan_turn(IDX);
        end else begin
          x_r[i] <= x_src + (y_src >>> i);
          z_r[i] <= z_src + atan_turn(IDX);
        end
      end
    end

    // the last stage leaves y unused
    if (i < STAGES - 1) begin : g_y
      always_ff @(posedge clk) begin
        if (en) begin
          if (y_src[CW-1]) begin
            y_r[i] <= y_src + (x_src >>> i);
          end else begin
            y_r[i] <= y_src - (x_src >>> i);
          end
        end
      end
    end
  end

  assign x_out = x_r[STAGES-1];
  assign z_out = z_r[STAGES-1];

endmodule

// File: design/rotation_matrix_to_euler.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// ZYX Euler angles (roll, pitch, yaw) from a Q1.14 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one matrix beat (seven Q1.14 entries) per accepted cycle.
//   out_*  : one angle beat per matrix, in order; angles are binary angles
//            with 32768 = pi, singular_flag marks the gimbal-lock branch.
//   cfg_*  : writes singular_threshold (Q1.14); cfg_ready is always high.
// Throughput: one matrix per cycle when not stalled. Path: input register,
//   yaw/magnitude CORDIC, split magnitude multiply (partial-product and sum
//   registers), pitch CORDIC fed by that magnitude, output register.
//   The two CORDIC chains in series set the latency; both roll candidates
//   run beside the yaw chain and are picked at the output.
// Reset: rst_n (synchronous, active low) empties the pipeline and sets the
//   threshold to 1.
// Stall: the whole pipeline holds while out_valid is high and out_stall is
//   high; in_stall is raised in exactly those cycles, so nothing is lost.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler
  import rme_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rme_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rme_out_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  localparam int NSTG  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int DEPTH = 2 * NSTG + 4;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic        [31:0]   z;
    logic                 zero;
  } vec_t;

  // side data that follows the yaw CORDIC
  typedef struct packed {
    logic signed [15:0] m20;
    logic               yaw_zero;
    logic               rn_zero;
    logic               rs_zero;
  } sba_t;

  // side data that follows the pitch CORDIC
  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] roll_n;
    logic [15:0] roll_s;
    logic        singular;
    logic        pitch_zero;
  } sbb_t;

  // scale to guard bits and fold the left half-plane over by pi
  function automatic vec_t prerot(input logic signed [16:0] xi,
                                  input logic signed [16:0] yi);
    vec_t v;
    logic signed [CW-1:0] xg;
    logic signed [CW-1:0] yg;
    xg = {{(CW-17-GUARD_BITS){xi[16]}}, xi, {GUARD_BITS{1'b0}}};
    yg = {{(CW-17-GUARD_BITS){yi[16]}}, yi, {GUARD_BITS{1'b0}}};
    v.zero = (xi == '0) && (yi == '0);
    if (xi[16]) begin
      v.x = -xg;
      v.y = -yg;
      v.z = 32'h8000_0000;
    end else begin
      v.x = xg;
      v.y = yg;
      v.z = 32'h0;
    end
    return v;
  endfunction

  // round a turn-unit angle to 16 bits
  function automatic logic [15:0] round16(input logic [31:0] z);
    return z[31:16] + 16'(z[15]);
  endfunction

  logic                 en;
  logic [DEPTH-1:0]     vld_r;
  logic [14:0]          thr_r;
  rme_in_t              in_r;
  vec_t                 va, vrn, vrs;
  logic signed [CW-1:0] ax, px;
  logic        [31:0]   az, rnz, rsz, pz;
  sba_t                 sba_nxt;
  sba_t                 sba_r [NSTG];
  logic [33:0]          xa;
  logic [32:0]          plo_nxt, phi_nxt;
  logic [32:0]          plo_r, phi_r;
  logic [15:0]          yaw_m1_r, rn_m1_r, rs_m1_r;
  logic signed [15:0]   m20_m1_r;
  logic [49:0]          prod;
  logic [33:0]          syg_r;
  logic [15:0]          yaw_m2_r, rn_m2_r, rs_m2_r;
  logic signed [15:0]   m20_m2_r;
  logic [34:0]          sy_rnd;
  logic signed [CW-1:0] py_in;
  sbb_t                 sbb_nxt;
  sbb_t                 sbb_r [NSTG];
  rme_out_t             out_nxt;
  rme_out_t             out_r;

  // advance whenever the output register is free or being taken
  assign en        = !vld_r[DEPTH-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'd1;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // valid bits, one per pipeline position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
    end
  end

  // fold the three input vectors
  always_comb begin
    va  = prerot({in_r.m00[15], in_r.m00}, {in_r.m10[15], in_r.m10});
    vrn = prerot({in_r.m22[15], in_r.m22}, {in_r.m21[15], in_r.m21});
    vrs = prerot({in_r.m11[15], in_r.m11}, -{in_r.m12[15], in_r.m12});
    sba_nxt.m20      = in_r.m20;
    sba_nxt.yaw_zero = va.zero;
    sba_nxt.rn_zero  = vrn.zero;
    sba_nxt.rs_zero  = vrs.zero;
  end

  rme_cordic #(.STAGES(NSTG)) u_cordic_yaw (
    .clk(clk), .en(en), .x_in(va.x), .y_in(va.y), .z_in(va.z),
    .x_out(ax), .z_out(az)
  );

  rme_cordic #(.STAGES(NSTG)) u_cordic_roll_n (
    .clk(clk), .en(en), .x_in(vrn.x), .y_in(vrn.y), .z_in(vrn.z),
    .x_out(), .z_out(rnz)
  );

  rme_cordic #(.STAGES(NSTG)) u_cordic_roll_s (
    .clk(clk), .en(en), .x_in(vrs.x), .y_in(vrs.y), .z_in(vrs.z),
    .x_out(), .z_out(rsz)
  );

  // carry side data alongside the first CORDIC chains
  always_ff @(posedge clk) begin
    if (en) begin
      sba_r[0] <= sba_nxt;
      for (int k = 1; k < NSTG; k++) begin
        sba_r[k] <= sba_r[k-1];
      end
    end
  end

  // split the gain correction into two partial products
  always_comb begin
    xa      = (ax > '0) ? ax[33:0] : '0;
    plo_nxt = 33'(xa[16:0]) * 33'(INV_GAIN);
    phi_nxt = 33'(xa[33:17]) * 33'(INV_GAIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
      yaw_m1_r <= sba_r[NSTG-1].yaw_zero ? 16'h0 : round16(az);
      rn_m1_r  <= sba_r[NSTG-1].rn_zero  ? 16'h0 : round16(rnz);
      rs_m1_r  <= sba_r[NSTG-1].rs_zero  ? 16'h0 : round16(rsz);
      m20_m1_r <= sba_r[NSTG-1].m20;
    end
  end

  // sum the partial products into sy with guard bits
  assign prod = {phi_r, 17'h0} + 50'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      syg_r    <= prod[49:16];
      yaw_m2_r <= yaw_m1_r;
      rn_m2_r  <= rn_m1_r;
      rs_m2_r  <= rs_m1_r;
      m20_m2_r <= m20_m1_r;
    end
  end

  // pitch vector and gimbal-lock test
  always_comb begin
    px     = {{(CW-34){1'b0}}, syg_r};
    py_in  = -{{(CW-16-GUARD_BITS){m20_m2_r[15]}}, m20_m2_r, {GUARD_BITS{1'b0}}};
    sy_rnd = 35'(syg_r) + 35'h8000;
    sbb_nxt.yaw        = yaw_m2_r;
    sbb_nxt.roll_n     = rn_m2_r;
    sbb_nxt.roll_s     = rs_m2_r;
    sbb_nxt.singular   = sy_rnd[34:16] < 19'(thr_r);
    sbb_nxt.pitch_zero = (syg_r == '0) && (m20_m2_r == '0);
  end

  rme_cordic #(.STAGES(NSTG)) u_cordic_pitch (
    .clk(clk), .en(en), .x_in(px), .y_in(py_in), .z_in(32'h0),
    .x_out(), .z_out(pz)
  );

  // carry side data alongside the pitch chain
  always_ff @(posedge clk) begin
    if (en) begin
      sbb_r[0] <= sbb_nxt;
      for (int k = 1; k < NSTG; k++) begin
        sbb_r[k] <= sbb_r[k-1];
      end
    end
  end

  // pick the branch and load the output register
  always_comb begin
    out_nxt.pitch_angle   = sbb_r[NSTG-1].pitch_zero ? 16'sh0 : $signed(round16(pz));
    out_nxt.singular_flag = sbb_r[NSTG-1].singular;
    if (sbb_r[NSTG-1].singular) begin
      out_nxt.roll_angle = $signed(sbb_r[NSTG-1].roll_s);
      out_nxt.yaw_angle  = 16'sh0;
    end else begin
      out_nxt.roll_angle = $signed(sbb_r[NSTG-1].roll_n);
      out_nxt.yaw_angle  = $signed(sbb_r[NSTG-1].yaw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  // yaw is forced to zero on the gimbal-lock branch
  a_sing_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular_flag |-> out_data.yaw_angle == 16'sh0)
    else $error("singular beat with non-zero yaw");

  // a zero threshold never selects the gimbal-lock branch
  a_thr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (thr_r == 15'h0) |-> !out_data.singular_flag)
    else $error("singular flag with zero threshold");

  // a beat at the last stage moves into the output register when advancing
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[DEPTH-2] |=> out_valid)
    else $error("beat lost before output register");

  // the pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // the input side stalls only while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");
`endif

endmodule

// File: test/euler_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angle_checker
// Watches the matrix, angle and threshold channels of the Euler angle block.
// Each accepted matrix beat is turned into the expected roll, pitch, yaw and
// gimbal-lock flag by a bit-exact CORDIC predictor, and every angle beat is
// compared field by field with the oldest expectation still waiting.
// ----------------------------------------------------------------------------
module euler_angle_checker
  import rme_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  rme_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  rme_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [14:0] cfg_data,
  output int          mismatch_count,
  output int          angles_pending
);

  localparam int STAGES_RUN = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  // 0.60725 * 2^16, undoes the CORDIC gain on the magnitude
  localparam longint GAIN_COMP = 39797;
  localparam longint GUARD_SCALE = 65536;

  // atan(2^-i) in turn units, 2^32 being a full circle
  localparam logic [31:0] ARC_TURN [24] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  logic [14:0] lock_threshold;
  rme_out_t    angles_due[$];
  rme_out_t    want_angles;

  // Vectoring CORDIC on guard-scaled operands: returns the binary angle of
  // (x, y) and hands back the gain-corrected magnitude, guard bits kept.
  function automatic logic [15:0] vector_angle(input longint y_g, input longint x_g,
                                               output longint mag_g);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    int          i;
    x     = x_g;
    y     = y_g;
    z     = 32'd0;
    mag_g = 0;
    // a zero vector has neither angle nor length
    if (x == 0 && y == 0) return 16'd0;
    // fold the left half-plane over by half a turn
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (i = 0; i < STAGES_RUN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARC_TURN[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARC_TURN[i];
      end
    end
    mag_g = (x > 0) ? ((x * GAIN_COMP) >>> 16) : 0;
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  // Expected angle beat for one matrix under the given lock threshold
  function automatic rme_out_t predict_angles(input rme_in_t m, input logic [14:0] thr);
    rme_out_t    r;
    longint      sy_g;
    longint      sy_q14;
    longint      spare_mag;
    logic [15:0] yaw;
    yaw    = vector_angle(longint'(m.m10) * GUARD_SCALE, longint'(m.m00) * GUARD_SCALE,
                          sy_g);
    sy_q14 = (sy_g + 32768) >>> 16;
    r.singular_flag = (sy_q14 < longint'(thr));
    // sy already carries the guard bits, so it goes in at full scale
    r.pitch_angle = vector_angle(-longint'(m.m20) * GUARD_SCALE, sy_g, spare_mag);
    if (r.singular_flag) begin
      r.roll_angle = vector_angle(-longint'(m.m12) * GUARD_SCALE,
                                  longint'(m.m11) * GUARD_SCALE, spare_mag);
      r.yaw_angle  = '0;
    end else begin
      r.roll_angle = vector_angle(longint'(m.m21) * GUARD_SCALE,
                                  longint'(m.m22) * GUARD_SCALE, spare_mag);
      r.yaw_angle  = yaw;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track the threshold, queue predictions, and match angle beats in order
  always @(posedge clk) begin
    if (!rst_n) begin
      lock_threshold <= 15'd1;
      angles_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) lock_threshold <= cfg_data;
      if (in_valid && !in_stall) angles_due.push_back(predict_angles(in_data, lock_threshold));
      if (out_valid && !out_stall) begin
        if (angles_due.size() == 0) begin
          $display("%0t: angle beat with none expected: expected nothing, actual %p",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want_angles = angles_due.pop_front();
          check_field("roll_angle", int'(want_angles.roll_angle), int'(out_data.roll_angle));
          check_field("pitch_angle", int'(want_angles.pitch_angle),
                      int'(out_data.pitch_angle));
          check_field("yaw_angle", int'(want_angles.yaw_angle), int'(out_data.yaw_angle));
          check_field("singular_flag", int'(want_angles.singular_flag),
                      int'(out_data.singular_flag));
        end
      end
    end
    angles_pending = angles_due.size();
  end

endmodule

// File: test/rotation_matrix_to_euler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_tb
// Drives matrix beats into the Euler angle block: corner matrices first, then
// random rotations, near and exact gimbal lock and raw noise, across several
// lock thresholds, with random gaps and stalls on both sides and one long
// output hold. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_tb
  import rme_pkg::*;
;

  localparam int  STAGES       = 16;
  localparam int  DRAIN_CYCLES = 2 * STAGES + 8;
  localparam int  PHASE_ITEMS  = 144;
  localparam int  LONG_HOLD    = 300;
  localparam int  HOLD_AT_BEAT = 250;
  localparam real PI           = 3.14159265358979;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rme_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  rme_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] cfg_data;
  int          mismatch_count;
  int          angles_pending;

  rotation_matrix_to_euler #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  euler_angle_checker #(
    .CORDIC_STAGES(STAGES)
  ) angle_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .angles_pending(angles_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [15:0] to_q14(input real v);
    return 16'($rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5)));
  endfunction

  function automatic real any_angle();
    return (real'($urandom_range(0, 65535)) / 32768.0 - 1.0) * PI;
  endfunction

  // ZYX rotation, R = Rz(yaw) * Ry(pitch) * Rx(roll), rounded to Q1.14
  function automatic rme_in_t euler_matrix(input real roll, input real pitch, input real yaw);
    real     cr;
    real     sr;
    real     cp;
    real     sp;
    real     cy;
    real     sy;
    rme_in_t m;
    cr = $cos(roll);
    sr = $sin(roll);
    cp = $cos(pitch);
    sp = $sin(pitch);
    cy = $cos(yaw);
    sy = $sin(yaw);
    m.m00 = to_q14(cy * cp);
    m.m10 = to_q14(sy * cp);
    m.m20 = to_q14(-sp);
    m.m21 = to_q14(cp * sr);
    m.m22 = to_q14(cp * cr);
    m.m11 = to_q14(sy * sp * sr + cy * cr);
    m.m12 = to_q14(sy * sp * cr - cy * sr);
    return m;
  endfunction

  // Noise entry: tiny values, the extremes, or any 16-bit pattern
  function automatic logic [15:0] raw_entry();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 8) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 16'sd16384;
          1:       return -16'sd16384;
          2:       return 16'sh7FFF;
          default: return 16'sh8000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rme_in_t random_matrix();
    int      kind;
    real     tilt;
    real     side;
    rme_in_t m;
    kind = $urandom_range(0, 99);
    side = ($urandom_range(0, 1) == 1) ? 1.0 : -1.0;
    if (kind < 50) begin
      m = euler_matrix(any_angle(), any_angle() / 2.0, any_angle());
    end else if (kind < 65) begin
      // pitch close to a pole, so sy lands near the lock threshold
      tilt = real'($urandom_range(0, 1000)) / 32768.0;
      m = euler_matrix(any_angle(), side * (PI / 2.0 - tilt), any_angle());
    end else if (kind < 75) begin
      // pitch exactly at a pole: first column collapses
      m = euler_matrix(any_angle(), side * PI / 2.0, any_angle());
      m.m00 = '0;
      m.m10 = '0;
    end else begin
      m = '{raw_entry(), raw_entry(), raw_entry(), raw_entry(), raw_entry(), raw_entry(),
            raw_entry()};
    end
    return m;
  endfunction

  // Offer one matrix beat after a random gap and hold it until taken
  task automatic send_matrix(input rme_in_t m, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Write the lock threshold once the pipeline has drained
  task automatic write_threshold(input logic [14:0] thr);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (angles_pending == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Matrix source, threshold phases and verdict
  initial begin
    rme_in_t     corner_mats[$];
    logic [14:0] thr_plan[$];
    bit          calm;
    int          k;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner matrices under the reset threshold
    corner_mats.push_back('{0, 0, 0, 0, 0, 0, 0});
    corner_mats.push_back('{16384, 0, 0, 0, 16384, 16384, 0});
    corner_mats.push_back('{-16384, 0, 0, 0, 16384, -16384, 0});
    corner_mats.push_back('{-16384, -1, 0, 0, -16384, 16384, 0});
    corner_mats.push_back('{0, 0, -16384, 0, 0, 16384, 0});
    corner_mats.push_back('{0, 0, 16384, 0, 0, 0, -16384});
    corner_mats.push_back('{0, 0, 16384, 5, 5, 0, 0});
    corner_mats.push_back('{16384, 0, 0, 0, 0, 0, 0});
    corner_mats.push_back('{16384, 16384, 16384, 16384, 16384, 16384, 16384});
    corner_mats.push_back('{-16384, -16384, -16384, -16384, -16384, -16384, -16384});
    corner_mats.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767});
    corner_mats.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, -32768});
    corner_mats.push_back('{21845, -21846, 21845, -21846, 21845, -21846, 21845});
    corner_mats.push_back('{1, 0, 0, -1, 0, 1, 1});
    corner_mats.push_back('{0, -1, 1, 0, -1, -1, 0});
    corner_mats.push_back('{-1, -1, -1, -1, -1, -1, -1});
    foreach (corner_mats[i]) send_matrix(corner_mats[i], 1'b0);

    // random phases, each under its own lock threshold
    thr_plan = '{15'd0, 15'd300, 15'd16384, 15'd32767, 15'($urandom_range(0, 600)),
                 15'($urandom_range(0, 32767)), 15'd1, 15'($urandom_range(0, 600))};
    calm = 1'b0;
    foreach (thr_plan[p]) begin
      write_threshold(thr_plan[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 36 == 0) calm = ($urandom_range(0, 3) == 0);
        send_matrix(random_matrix(), calm);
      end
    end

    // drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    wait (angles_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Angle sink: random stalls, calm stretches, and one long hold so the
  // pipeline fills and pushes back on the matrix source
  initial begin
    int taken;
    int hold;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (taken == HOLD_AT_BEAT) begin
        hold = LONG_HOLD;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

endmodule

// File: sim.f
design/rme_pkg.sv
design/rme_cordic.sv
design/rotation_matrix_to_euler.sv
test/euler_angle_checker.sv
test/rotation_matrix_to_euler_tb.sv
